// File: rtl/bcc_pkg.sv
// shared types, constants and register codes for the button click classifier
package bcc_pkg;

    localparam int BUTTONS = 8;
    localparam int ADDR_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

    localparam int NUM_REGS = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SHORT_MAX    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_CLICK    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MULTI_WINDOW = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STUCK_EXTRA  = 3'd5;

    localparam logic [1:0] CLICK_MAX = 2'd3;

    typedef enum logic [2:0] {
        EV_IDLE    = 3'd0,
        EV_PRESSED = 3'd1,
        EV_SHORT   = 3'd2,
        EV_LONG    = 3'd3,
        EV_DOUBLE  = 3'd4,
        EV_TRIPLE  = 3'd5
    } event_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] short_press_max_ms;
        logic [15:0] min_click_ms;
        logic [15:0] multi_click_window_ms;
        logic [15:0] stuck_extra_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        debounce_ms:           16'd50,
        long_press_ms:         16'd1000,
        short_press_max_ms:    16'd500,
        min_click_ms:          16'd20,
        multi_click_window_ms: 16'd400,
        stuck_extra_ms:        16'd700
    };

    typedef struct packed {
        logic        raw_last;
        logic        stable_last;
        logic        released_flag;
        logic [31:0] edge_time;
        logic [31:0] press_start;
        logic [31:0] press_length;
        logic [1:0]  click_count;
        logic [31:0] click_time;
        logic        click_valid;
        logic [31:0] long_end_time;
        event_t      event_code;
    } btn_state_t;

    localparam btn_state_t STATE_RESET = '{
        raw_last:      1'b0,
        stable_last:   1'b0,
        released_flag: 1'b1,
        edge_time:     32'd0,
        press_start:   32'd0,
        press_length:  32'd0,
        click_count:   2'd0,
        click_time:    32'd0,
        click_valid:   1'b0,
        long_end_time: 32'd0,
        event_code:    EV_IDLE
    };

endpackage

// File: rtl/button_click_classifier.sv
// button click classifier top level: request pipeline, state memory and configuration
// A sample request can be taken every cycle while in_stall is low; it is held in the update
// stage and then in the result register. In the accept cycle it reads its button's entry
// from a small state ram. When the update stage advances, the update logic writes the
// updated entry back and loads the result register, which offers it. The result is held
// in the output register while out_stall is high. The input stalls only when the update
// stage and the result register are both occupied and out_stall is high. A request for the
// same button straight after another gets the freshly written entry by forwarding. After
// reset every entry reads as its reset value through per button valid bits, so there is
// no clearing pass. Configuration is written through cfg_valid/cfg_ready, which is always
// ready, and must only change while no request is in flight.
module button_click_classifier (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         button_index,
    input  logic                               pin_level,
    input  logic [31:0]                        now_ms,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         event_state,
    output logic [31:0]                        press_length_ms,
    output logic                               stable_level,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bcc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                        cfg_data
);
    import bcc_pkg::*;

    localparam int STATE_W = $bits(btn_state_t);

    cfg_t              cfg_reg;
    logic              in_accept;
    logic              s1_valid_reg;
    logic              s1_advance;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_in_range_reg;
    logic              s1_pin_reg;
    logic [31:0]       s1_now_reg;
    logic              fwd_hit_reg;
    btn_state_t        fwd_data_reg;
    logic              ent_valid_reg;
    logic [BUTTONS-1:0] valid_bits_reg;
    logic [ADDR_W-1:0] in_addr;
    logic              in_range;
    logic [STATE_W-1:0] ram_rdata;
    btn_state_t        cur_state;
    btn_state_t        nxt_state;
    logic              wr_en;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [2:0]        event_state_reg;
    logic [31:0]       press_length_reg;
    logic              stable_level_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE:     cfg_reg.debounce_ms <= cfg_data;
                REG_LONG_PRESS:   cfg_reg.long_press_ms <= cfg_data;
                REG_SHORT_MAX:    cfg_reg.short_press_max_ms <= cfg_data;
                REG_MIN_CLICK:    cfg_reg.min_click_ms <= cfg_data;
                REG_MULTI_WINDOW: cfg_reg.multi_click_window_ms <= cfg_data;
                REG_STUCK_EXTRA:  cfg_reg.stuck_extra_ms <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // request handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;
    assign in_addr    = ADDR_W'(button_index);
    assign in_range   = (32'(button_index) < BUTTONS);
    assign wr_en      = s1_advance && s1_in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
            s1_pin_reg      <= pin_level;
            s1_now_reg      <= now_ms;
            ent_valid_reg   <= valid_bits_reg[in_addr];
            fwd_hit_reg     <= wr_en && (s1_addr_reg == in_addr);
            fwd_data_reg    <= nxt_state;
        end
    end

    // per button valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_bits_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_bits_reg[s1_addr_reg] <= 1'b1;
        end
    end

    bcc_ram #(
        .WIDTH (STATE_W),
        .DEPTH (BUTTONS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (nxt_state),
        .re    (in_accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_state = fwd_data_reg;
        end
        else if (ent_valid_reg)
        begin
            cur_state = btn_state_t'(ram_rdata);
        end
        else
        begin
            cur_state = STATE_RESET;
        end
    end

    bcc_update u_update (
        .cur_state (cur_state),
        .pin_level (s1_pin_reg),
        .now_ms    (s1_now_reg),
        .cfg       (cfg_reg),
        .nxt_state (nxt_state)
    );

    // result register
    always_comb
    begin
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            if (s1_in_range_reg)
            begin
                event_state_reg  <= 3'(nxt_state.event_code);
                press_length_reg <= nxt_state.press_length;
                stable_level_reg <= nxt_state.stable_last;
            end
            else
            begin
                event_state_reg  <= 3'(EV_IDLE);
                press_length_reg <= 32'd0;
                stable_level_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_state     = event_state_reg;
    assign press_length_ms = press_length_reg;
    assign stable_level    = stable_level_reg;

`ifndef SYNTHESIS
    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("request stalled with no blocked result");

    a_write_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s1_valid_reg && s1_in_range_reg))
        else $error("state write without a request in the update stage");

    a_result_follows_update: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("updated request produced no result");

    a_entry_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_bits_reg[$past(s1_addr_reg)])
        else $error("written entry not marked valid");
`endif

endmodule

// File: rtl/bcc_ram.sv
// generic single write port ram with registered read
module bcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bcc_update.sv
// per button state update: debounce, press classification, finalising and expiry
module bcc_update (
    input  bcc_pkg::btn_state_t cur_state,
    input  logic                pin_level,
    input  logic [31:0]         now_ms,
    input  bcc_pkg::cfg_t       cfg,
    output bcc_pkg::btn_state_t nxt_state
);
    import bcc_pkg::*;

    always_comb
    begin
        btn_state_t s;
        logic [31:0] len;
        logic [31:0] window;
        logic [31:0] expire;
        logic [31:0] ref_time;
        logic        have;

        s = cur_state;
        window = 32'(cfg.multi_click_window_ms);
        expire = 32'(cfg.multi_click_window_ms) + 32'(cfg.stuck_extra_ms);
        len = now_ms - s.press_start;
        ref_time = 32'd0;
        have = 1'b0;

        if (pin_level != s.raw_last)
        begin
            s.edge_time = now_ms;
        end

        if (((now_ms - s.edge_time) > 32'(cfg.debounce_ms)) && (pin_level != s.stable_last))
        begin
            s.stable_last = pin_level;
            if (pin_level)
            begin
                if (s.released_flag)
                begin
                    s.released_flag = 1'b0;
                    s.press_start = now_ms;
                    if (s.event_code != EV_LONG)
                    begin
                        s.event_code = EV_PRESSED;
                    end
                end
            end
            else if (!s.released_flag)
            begin
                // debounced release: classify the press
                s.released_flag = 1'b1;
                s.press_length = len;
                if (len > 32'(cfg.long_press_ms))
                begin
                    s.event_code = EV_LONG;
                    s.long_end_time = now_ms;
                    s.click_count = 2'd0;
                    s.click_time = 32'd0;
                    s.click_valid = 1'b0;
                end
                else if ((len >= 32'(cfg.min_click_ms)) && (len <= 32'(cfg.short_press_max_ms)))
                begin
                    if (s.event_code == EV_LONG)
                    begin
                        s.event_code = EV_IDLE;
                        s.click_count = 2'd0;
                        s.click_time = 32'd0;
                        s.click_valid = 1'b0;
                    end
                    else
                    begin
                        if ((s.click_count != 2'd0) && ((now_ms - s.click_time) < window))
                        begin
                            if (s.click_count != CLICK_MAX)
                            begin
                                s.click_count = s.click_count + 2'd1;
                            end
                        end
                        else
                        begin
                            s.click_count = 2'd1;
                        end
                        s.click_time = now_ms;
                        s.click_valid = 1'b1;
                        if (s.event_code == EV_PRESSED)
                        begin
                            s.event_code = EV_IDLE;
                        end
                    end
                end
                else
                begin
                    if (s.event_code != EV_LONG)
                    begin
                        s.event_code = EV_IDLE;
                    end
                    s.click_count = 2'd0;
                    s.click_time = 32'd0;
                    s.click_valid = 1'b0;
                end
            end
        end
        s.raw_last = pin_level;

        if (!s.released_flag && s.stable_last)
        begin
            s.press_length = now_ms - s.press_start;
        end

        // quiet window over: finalise the click series
        if ((s.click_count != 2'd0) && s.click_valid && ((now_ms - s.click_time) >= window))
        begin
            if ((s.event_code == EV_IDLE) || (s.event_code == EV_PRESSED))
            begin
                if (s.click_count == 2'd1)
                begin
                    s.event_code = EV_SHORT;
                end
                else if (s.click_count == 2'd2)
                begin
                    s.event_code = EV_DOUBLE;
                end
                else
                begin
                    s.event_code = EV_TRIPLE;
                end
            end
            s.click_count = 2'd0;
        end

        // finished events time out
        case (s.event_code)
            EV_LONG:
            begin
                have = 1'b1;
                ref_time = s.long_end_time;
            end
            EV_SHORT, EV_DOUBLE, EV_TRIPLE:
            begin
                have = s.click_valid;
                ref_time = s.click_time;
            end
            default:
            begin
                have = 1'b0;
                ref_time = 32'd0;
            end
        endcase
        if (have && ((now_ms - ref_time) > expire))
        begin
            s.event_code = EV_IDLE;
            s.click_count = 2'd0;
            s.click_time = 32'd0;
            s.click_valid = 1'b0;
        end

        if ((s.event_code == EV_PRESSED) && s.released_flag)
        begin
            s.event_code = EV_IDLE;
        end

        nxt_state = s;
    end

endmodule
